@@ design/phsmq_pkg.sv @@
// phsmq_pkg: shared types, widths and codes for the pH session median qualifier
// no dependencies; used by phsmq_alu and ph_session_median_qualifier
`default_nettype none

package phsmq_pkg;

   // sample capacity of one session
   localparam int MAX_SAMPLES = 8;

   // field widths
   localparam int PH_W      = 14;
   localparam int RUN_W     = 4;
   localparam int KEEP_W    = 4;
   localparam int VERDICT_W = 3;
   localparam int CSR_IDX_W = 3;

   // store index and fill count widths follow the capacity
   localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SAMPLES);
   localparam logic [RUN_W-1:0] RUN_MAX  = {RUN_W{1'b1}};

   // configuration reset values
   localparam logic [PH_W-1:0]  NOISE_LIMIT_RST     = 14'd200;
   localparam logic [PH_W-1:0]  SHOCK_LIMIT_RST     = 14'd500;
   localparam logic [PH_W-1:0]  VALID_LOW_RST       = 14'd3000;
   localparam logic [PH_W-1:0]  VALID_HIGH_RST      = 14'd10000;
   localparam logic [RUN_W-1:0] NOISY_RUN_LIMIT_RST = 4'd3;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_LIMIT     = 3'd0,
      CSR_SHOCK_LIMIT     = 3'd1,
      CSR_VALID_LOW       = 3'd2,
      CSR_VALID_HIGH      = 3'd3,
      CSR_NOISY_RUN_LIMIT = 3'd4
   } csr_index_type;

   // verdict codes
   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_EMPTY   = 3'd0,
      VERDICT_NOISY   = 3'd1,
      VERDICT_SUSPECT = 3'd2,
      VERDICT_CONFIRM = 3'd3,
      VERDICT_ACCEPT  = 3'd4
   } verdict_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_LOW,
      S_HIGH,
      S_INS,
      S_MAXRD,
      S_SPREAD,
      S_MIDRD,
      S_MED,
      S_CHG1,
      S_CHG2,
      S_NOISE,
      S_SHOCK,
      S_DECIDE
   } state_type;

   // shared adder operations
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type      op;
      logic [PH_W-1:0] a;
      logic [PH_W-1:0] b;
   } alu_req_type;

   // carry is the sum's top bit on add and the borrow on subtract
   typedef struct packed {
      logic            carry;
      logic [PH_W-1:0] value;
   } alu_rsp_type;

endpackage

`default_nettype wire

@@ design/phsmq_alu.sv @@
// phsmq_alu: shared add/subtract unit of the qualifier sequencer
// depends on phsmq_pkg for operand and result types
`default_nettype none

module phsmq_alu (
   input  phsmq_pkg::alu_req_type alu_req,
   output phsmq_pkg::alu_rsp_type alu_rsp
);

   logic [phsmq_pkg::PH_W:0] a_ext;
   logic [phsmq_pkg::PH_W:0] b_ext;
   logic [phsmq_pkg::PH_W:0] res;

   assign a_ext = {1'b0, alu_req.a};
   assign b_ext = {1'b0, alu_req.b};

   // one extra bit holds carry out or borrow
   always_comb begin
      case (alu_req.op)
         phsmq_pkg::ALU_ADD: res = a_ext + b_ext;
         phsmq_pkg::ALU_SUB: res = a_ext - b_ext;
         default:            res = a_ext - b_ext;
      endcase
   end

   assign alu_rsp.carry = res[phsmq_pkg::PH_W];
   assign alu_rsp.value = res[phsmq_pkg::PH_W-1:0];

endmodule

`default_nettype wire

@@ design/ph_session_median_qualifier.sv @@
// ph_session_median_qualifier: top level, sample store, sequencer and verdict logic
// depends on phsmq_pkg and phsmq_alu
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall sample_ph, read_ok, session_end
//   rsp      out        rsp_valid/rsp_stall verdict and seven report fields
//   csr      in         csr_valid/csr_ready csr_index, csr_wdata
//
// a sample with read_ok low is handled in idle alone; one that fails the range
// check or meets a full store goes through the low and, if reached, high check;
// a kept sample then enters insertion, which shifts one entry a cycle through the
// single shared adder; a session end with kept samples runs adder steps for
// spread, median, change and limit compares, then waits for the rsp register to free
// req_stall is high whenever the sequencer is busy; rsp holds one result register
// reset is synchronous; csr_ready is always high
`default_nettype none

module ph_session_median_qualifier (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // sample channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [phsmq_pkg::PH_W-1:0]          req_sample_ph,
   input  wire logic                                req_read_ok,
   input  wire logic                                req_session_end,
   // verdict channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [phsmq_pkg::VERDICT_W-1:0]          rsp_verdict,
   output logic [phsmq_pkg::PH_W-1:0]               rsp_median_ph,
   output logic [phsmq_pkg::PH_W-1:0]               rsp_spread_ph,
   output logic [phsmq_pkg::PH_W-1:0]               rsp_prior_reference,
   output logic                                     rsp_prior_reference_valid,
   output logic [phsmq_pkg::PH_W-1:0]               rsp_change_ph,
   output logic [phsmq_pkg::KEEP_W-1:0]             rsp_kept_count,
   output logic                                     rsp_reference_cleared,
   // configuration channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [phsmq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [phsmq_pkg::PH_W-1:0]          csr_wdata
);

   localparam int PH_W  = phsmq_pkg::PH_W;
   localparam int RUN_W = phsmq_pkg::RUN_W;
   localparam int IDX_W = phsmq_pkg::IDX_W;
   localparam int CNT_W = phsmq_pkg::CNT_W;

   // configuration registers
   logic [PH_W-1:0]  noise_limit_ff;
   logic [PH_W-1:0]  shock_limit_ff;
   logic [PH_W-1:0]  valid_low_ff;
   logic [PH_W-1:0]  valid_high_ff;
   logic [RUN_W-1:0] run_limit_ff;

   // sample store, kept sorted ascending
   logic [PH_W-1:0]  store_ff [phsmq_pkg::MAX_SAMPLES];
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [PH_W-1:0]  wr_data;
   logic [CNT_W-1:0] rd_sel;
   logic [IDX_W-1:0] rd_addr;
   logic [PH_W-1:0]  rd_data;

   // sequencer and working registers
   phsmq_pkg::state_type state_ff, state_in;
   logic [PH_W-1:0]  sample_ff, sample_in;
   logic             end_ff, end_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [PH_W-1:0]  tmp_ff, tmp_in;
   logic [PH_W-1:0]  spread_ff, spread_in;
   logic [PH_W-1:0]  median_ff, median_in;
   logic [PH_W-1:0]  change_ff, change_in;
   logic             noisy_ff, noisy_in;
   logic             shock_ff, shock_in;

   // session history
   logic [PH_W-1:0]  ref_ff, ref_in;
   logic             ref_valid_ff, ref_valid_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             pend_ff, pend_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   phsmq_pkg::verdict_type rsp_verdict_ff, rsp_verdict_in;
   logic [PH_W-1:0]        rsp_median_ff, rsp_median_in;
   logic [PH_W-1:0]        rsp_spread_ff, rsp_spread_in;
   logic [PH_W-1:0]        rsp_prior_ff, rsp_prior_in;
   logic                   rsp_prior_valid_ff, rsp_prior_valid_in;
   logic [PH_W-1:0]        rsp_change_ff, rsp_change_in;
   logic [phsmq_pkg::KEEP_W-1:0] rsp_kept_ff, rsp_kept_in;
   logic                   rsp_cleared_ff, rsp_cleared_in;

   phsmq_pkg::alu_req_type alu_req;
   phsmq_pkg::alu_rsp_type alu_rsp;

   logic             req_beat;
   logic             out_free;
   logic [PH_W-1:0]  prior;
   logic [RUN_W-1:0] run_inc;
   logic             run_hit;

   phsmq_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_stall = (state_ff != phsmq_pkg::S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign rd_addr = rd_sel[IDX_W-1:0];
   assign rd_data = store_ff[rd_addr];

   assign prior   = ref_valid_ff ? ref_ff : '0;
   assign run_inc = (run_ff == phsmq_pkg::RUN_MAX) ? run_ff : run_ff + 1'b1;
   assign run_hit = (run_inc >= run_limit_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_limit_ff <= phsmq_pkg::NOISE_LIMIT_RST;
         shock_limit_ff <= phsmq_pkg::SHOCK_LIMIT_RST;
         valid_low_ff   <= phsmq_pkg::VALID_LOW_RST;
         valid_high_ff  <= phsmq_pkg::VALID_HIGH_RST;
         run_limit_ff   <= phsmq_pkg::NOISY_RUN_LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (phsmq_pkg::csr_index_type'(csr_index))
            phsmq_pkg::CSR_NOISE_LIMIT:     noise_limit_ff <= csr_wdata;
            phsmq_pkg::CSR_SHOCK_LIMIT:     shock_limit_ff <= csr_wdata;
            phsmq_pkg::CSR_VALID_LOW:       valid_low_ff   <= csr_wdata;
            phsmq_pkg::CSR_VALID_HIGH:      valid_high_ff  <= csr_wdata;
            phsmq_pkg::CSR_NOISY_RUN_LIMIT: run_limit_ff   <= csr_wdata[RUN_W-1:0];
            default: ;
         endcase
      end
   end

   // store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= phsmq_pkg::S_IDLE;
         cnt_ff       <= '0;
         ref_ff       <= '0;
         ref_valid_ff <= 1'b0;
         run_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ref_ff       <= ref_in;
         ref_valid_ff <= ref_valid_in;
         run_ff       <= run_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      sample_ff          <= sample_in;
      end_ff             <= end_in;
      j_ff               <= j_in;
      tmp_ff             <= tmp_in;
      spread_ff          <= spread_in;
      median_ff          <= median_in;
      change_ff          <= change_in;
      noisy_ff           <= noisy_in;
      shock_ff           <= shock_in;
      rsp_verdict_ff     <= rsp_verdict_in;
      rsp_median_ff      <= rsp_median_in;
      rsp_spread_ff      <= rsp_spread_in;
      rsp_prior_ff       <= rsp_prior_in;
      rsp_prior_valid_ff <= rsp_prior_valid_in;
      rsp_change_ff      <= rsp_change_in;
      rsp_kept_ff        <= rsp_kept_in;
      rsp_cleared_ff     <= rsp_cleared_in;
   end

   // sequencer: next state, store access and adder operands
   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      end_in       = end_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      tmp_in       = tmp_ff;
      spread_in    = spread_ff;
      median_in    = median_ff;
      change_in    = change_ff;
      noisy_in     = noisy_ff;
      shock_in     = shock_ff;
      ref_in       = ref_ff;
      ref_valid_in = ref_valid_ff;
      run_in       = run_ff;
      pend_in      = pend_ff;

      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_verdict_in     = rsp_verdict_ff;
      rsp_median_in      = rsp_median_ff;
      rsp_spread_in      = rsp_spread_ff;
      rsp_prior_in       = rsp_prior_ff;
      rsp_prior_valid_in = rsp_prior_valid_ff;
      rsp_change_in      = rsp_change_ff;
      rsp_kept_in        = rsp_kept_ff;
      rsp_cleared_in     = rsp_cleared_ff;

      wr_en   = 1'b0;
      wr_addr = j_ff[IDX_W-1:0];
      wr_data = sample_ff;
      rd_sel  = '0;
      alu_req = '{op: phsmq_pkg::ALU_SUB, a: sample_ff, b: valid_low_ff};

      case (state_ff)
         phsmq_pkg::S_IDLE: begin
            if (req_beat) begin
               sample_in = req_sample_ph;
               end_in    = req_session_end;
               if (req_read_ok) begin
                  state_in = phsmq_pkg::S_LOW;
               end else if (req_session_end) begin
                  state_in = (cnt_ff == '0) ? phsmq_pkg::S_DECIDE : phsmq_pkg::S_MAXRD;
               end
            end
         end

         // sample >= valid_low
         phsmq_pkg::S_LOW: begin
            alu_req = '{op: phsmq_pkg::ALU_SUB, a: sample_ff, b: valid_low_ff};
            if (alu_rsp.carry) begin
               if (end_ff) begin
                  state_in = (cnt_ff == '0) ? phsmq_pkg::S_DECIDE : phsmq_pkg::S_MAXRD;
               end else begin
                  state_in = phsmq_pkg::S_IDLE;
               end
            end else begin
               state_in = phsmq_pkg::S_HIGH;
            end
         end

         // sample <= valid_high and room left
         phsmq_pkg::S_HIGH: begin
            alu_req = '{op: phsmq_pkg::ALU_SUB, a: valid_high_ff, b: sample_ff};
            if (alu_rsp.carry || (cnt_ff >= phsmq_pkg::CNT_FULL)) begin
               if (end_ff) begin
                  state_in = (cnt_ff == '0) ? phsmq_pkg::S_DECIDE : phsmq_pkg::S_MAXRD;
               end else begin
                  state_in = phsmq_pkg::S_IDLE;
               end
            end else begin
               j_in     = cnt_ff;
               state_in = phsmq_pkg::S_INS;
            end
         end

         // insertion: shift larger entries up one slot a cycle
         phsmq_pkg::S_INS: begin
            rd_sel  = j_ff - 1'b1;
            alu_req = '{op: phsmq_pkg::ALU_SUB, a: sample_ff, b: rd_data};
            wr_en   = 1'b1;
            if ((j_ff != '0) && alu_rsp.carry) begin
               wr_data = rd_data;
               j_in    = j_ff - 1'b1;
            end else begin
               wr_data  = sample_ff;
               cnt_in   = cnt_ff + 1'b1;
               state_in = end_ff ? phsmq_pkg::S_MAXRD : phsmq_pkg::S_IDLE;
            end
         end

         // largest kept sample
         phsmq_pkg::S_MAXRD: begin
            rd_sel   = cnt_ff - 1'b1;
            tmp_in   = rd_data;
            state_in = phsmq_pkg::S_SPREAD;
         end

         // spread = max - min
         phsmq_pkg::S_SPREAD: begin
            rd_sel    = '0;
            alu_req   = '{op: phsmq_pkg::ALU_SUB, a: tmp_ff, b: rd_data};
            spread_in = alu_rsp.value;
            state_in  = phsmq_pkg::S_MIDRD;
         end

         // upper middle entry
         phsmq_pkg::S_MIDRD: begin
            rd_sel   = cnt_ff >> 1;
            tmp_in   = rd_data;
            state_in = phsmq_pkg::S_MED;
         end

         // median, floor of the middle pair's mean for an even count
         phsmq_pkg::S_MED: begin
            rd_sel  = (cnt_ff >> 1) - 1'b1;
            alu_req = '{op: phsmq_pkg::ALU_ADD, a: rd_data, b: tmp_ff};
            if (cnt_ff[0]) begin
               median_in = tmp_ff;
            end else begin
               median_in = {alu_rsp.carry, alu_rsp.value[PH_W-1:1]};
            end
            state_in = phsmq_pkg::S_CHG1;
         end

         // change = |median - reference|
         phsmq_pkg::S_CHG1: begin
            alu_req = '{op: phsmq_pkg::ALU_SUB, a: median_ff, b: prior};
            if (!ref_valid_ff) begin
               change_in = '0;
               state_in  = phsmq_pkg::S_NOISE;
            end else if (alu_rsp.carry) begin
               state_in  = phsmq_pkg::S_CHG2;
            end else begin
               change_in = alu_rsp.value;
               state_in  = phsmq_pkg::S_NOISE;
            end
         end

         phsmq_pkg::S_CHG2: begin
            alu_req   = '{op: phsmq_pkg::ALU_SUB, a: prior, b: median_ff};
            change_in = alu_rsp.value;
            state_in  = phsmq_pkg::S_NOISE;
         end

         // spread > noise_limit
         phsmq_pkg::S_NOISE: begin
            alu_req  = '{op: phsmq_pkg::ALU_SUB, a: noise_limit_ff, b: spread_ff};
            noisy_in = alu_rsp.carry;
            state_in = phsmq_pkg::S_SHOCK;
         end

         // change > shock_limit
         phsmq_pkg::S_SHOCK: begin
            alu_req  = '{op: phsmq_pkg::ALU_SUB, a: shock_limit_ff, b: change_ff};
            shock_in = alu_rsp.carry;
            state_in = phsmq_pkg::S_DECIDE;
         end

         // verdict, history update and result beat
         phsmq_pkg::S_DECIDE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_prior_in       = prior;
               rsp_prior_valid_in = ref_valid_ff;
               rsp_kept_in        = phsmq_pkg::KEEP_W'(cnt_ff);
               rsp_cleared_in     = 1'b0;
               cnt_in             = '0;
               state_in           = phsmq_pkg::S_IDLE;
               if (cnt_ff == '0) begin
                  // empty session leaves the history alone
                  rsp_verdict_in = phsmq_pkg::VERDICT_EMPTY;
                  rsp_median_in  = '0;
                  rsp_spread_in  = '0;
                  rsp_change_in  = '0;
               end else begin
                  rsp_median_in = median_ff;
                  rsp_spread_in = spread_ff;
                  rsp_change_in = change_ff;
                  if (noisy_ff) begin
                     rsp_verdict_in = phsmq_pkg::VERDICT_NOISY;
                     pend_in        = 1'b0;
                     if (run_hit) begin
                        ref_in         = '0;
                        ref_valid_in   = 1'b0;
                        run_in         = '0;
                        rsp_cleared_in = 1'b1;
                     end else begin
                        run_in = run_inc;
                     end
                  end else begin
                     run_in = '0;
                     if (ref_valid_ff && shock_ff) begin
                        if (!pend_ff) begin
                           pend_in        = 1'b1;
                           rsp_verdict_in = phsmq_pkg::VERDICT_SUSPECT;
                        end else begin
                           pend_in        = 1'b0;
                           ref_in         = median_ff;
                           rsp_verdict_in = phsmq_pkg::VERDICT_CONFIRM;
                        end
                     end else begin
                        pend_in        = 1'b0;
                        ref_in         = median_ff;
                        ref_valid_in   = 1'b1;
                        rsp_verdict_in = phsmq_pkg::VERDICT_ACCEPT;
                     end
                  end
               end
            end
         end

         default: begin
            state_in = phsmq_pkg::S_IDLE;
         end
      endcase
   end

   // result ports
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_verdict               = rsp_verdict_ff;
   assign rsp_median_ph             = rsp_median_ff;
   assign rsp_spread_ph             = rsp_spread_ff;
   assign rsp_prior_reference       = rsp_prior_ff;
   assign rsp_prior_reference_valid = rsp_prior_valid_ff;
   assign rsp_change_ph             = rsp_change_ff;
   assign rsp_kept_count            = rsp_kept_ff;
   assign rsp_reference_cleared     = rsp_cleared_ff;

   // fill count never passes capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= phsmq_pkg::CNT_FULL)
      else $error("sample count above capacity");

   // insertion slot stays inside the filled part of the store
   a_ins_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == phsmq_pkg::S_INS) |-> (j_ff <= cnt_ff))
      else $error("insertion slot beyond fill count");

   // a new result only comes out of the decide step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == phsmq_pkg::S_DECIDE))
      else $error("result raised outside decide step");

   // a delivered verdict empties the store
   a_store_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == phsmq_pkg::S_DECIDE && out_free) |=> (cnt_ff == '0))
      else $error("store not emptied after verdict");

   // only a noisy verdict can clear the reference
   a_clear_noisy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cleared_ff) |-> (rsp_verdict_ff == phsmq_pkg::VERDICT_NOISY))
      else $error("reference cleared without noisy verdict");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// testbench: directed and random sessions for ph_session_median_qualifier, checked beat by
// beat against an in-bench session predictor kept in a small scoreboard class
// depends on phsmq_pkg and the design sources
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import phsmq_pkg::*;

   localparam int PH_TOP        = (1 << PH_W) - 1;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 60;

   // one verdict beat as seen on the rsp channel
   typedef struct packed {
      verdict_type       verdict;
      logic [PH_W-1:0]   median;
      logic [PH_W-1:0]   spread;
      logic [PH_W-1:0]   prior;
      logic              prior_ok;
      logic [PH_W-1:0]   change;
      logic [KEEP_W-1:0] kept;
      logic              cleared;
   } verdict_beat_type;

   // session predictor plus the queue of verdicts still owed by the block
   class session_verdict_board_type;
      logic [PH_W-1:0]  noise_lim;
      logic [PH_W-1:0]  shock_lim;
      logic [PH_W-1:0]  range_lo;
      logic [PH_W-1:0]  range_hi;
      logic [RUN_W-1:0] run_lim;
      logic [PH_W-1:0]  kept_ph [MAX_SAMPLES];
      int unsigned      kept_n;
      logic [PH_W-1:0]  ref_ph;
      bit               ref_ok;
      logic [RUN_W-1:0] noisy_streak;
      bit               shock_wait;
      verdict_beat_type verdicts_due [$];
      int unsigned      errors;

      function new();
         noise_lim    = NOISE_LIMIT_RST;
         shock_lim    = SHOCK_LIMIT_RST;
         range_lo     = VALID_LOW_RST;
         range_hi     = VALID_HIGH_RST;
         run_lim      = NOISY_RUN_LIMIT_RST;
         kept_n       = 0;
         ref_ph       = '0;
         ref_ok       = 1'b0;
         noisy_streak = '0;
         shock_wait   = 1'b0;
         errors       = 0;
      endfunction

      function void note_config(csr_index_type idx, logic [PH_W-1:0] value);
         case (idx)
            CSR_NOISE_LIMIT: noise_lim = value;
            CSR_SHOCK_LIMIT: shock_lim = value;
            CSR_VALID_LOW: range_lo = value;
            CSR_VALID_HIGH: range_hi = value;
            CSR_NOISY_RUN_LIMIT: run_lim = value[RUN_W-1:0];
            default: ;
         endcase
      endfunction

      // insertion sort of the kept samples, floor of the middle pair for even counts
      function int unsigned median_of_kept(int unsigned n);
         int unsigned sorted [MAX_SAMPLES];
         int unsigned v;
         int unsigned j;
         for (int i = 0; i < n; i++) begin
            v = 32'(kept_ph[i]);
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = v;
         end
         if (n % 2 == 1) return sorted[n/2];
         return (sorted[n/2-1] + sorted[n/2]) >> 1;
      endfunction

      // one accepted sample beat; a session end queues the verdict it causes
      function void note_sample(logic [PH_W-1:0] ph, bit ok, bit last);
         verdict_beat_type due;
         int unsigned   n;
         int unsigned   lo;
         int unsigned   hi;
         int unsigned   med;
         int unsigned   prior;
         int unsigned   diff;
         if (ok && ph >= range_lo && ph <= range_hi && kept_n < MAX_SAMPLES) begin
            kept_ph[kept_n] = ph;
            kept_n++;
         end
         if (!last) return;
         n      = kept_n;
         kept_n = 0;
         prior  = ref_ok ? ref_ph : 0;
         due          = '0;
         due.verdict  = VERDICT_EMPTY;
         due.prior    = PH_W'(prior);
         due.prior_ok = ref_ok;
         due.kept     = KEEP_W'(n);
         if (n != 0) begin
            lo = 32'(kept_ph[0]);
            hi = 32'(kept_ph[0]);
            for (int i = 1; i < n; i++) begin
               if (kept_ph[i] < lo) lo = 32'(kept_ph[i]);
               if (kept_ph[i] > hi) hi = 32'(kept_ph[i]);
            end
            med  = median_of_kept(n);
            diff = !ref_ok ? 0 : (med >= prior ? med - prior : prior - med);
            due.median = PH_W'(med);
            due.spread = PH_W'(hi - lo);
            due.change = PH_W'(diff);
            if (hi - lo > noise_lim) begin
               // noisy session: count the streak, clear the reference at the limit
               due.verdict = VERDICT_NOISY;
               shock_wait  = 1'b0;
               if (noisy_streak != RUN_MAX) noisy_streak++;
               if (noisy_streak >= run_lim) begin
                  ref_ok       = 1'b0;
                  ref_ph       = '0;
                  noisy_streak = '0;
                  due.cleared  = 1'b1;
               end
            end else begin
               noisy_streak = '0;
               if (ref_ok && diff > shock_lim) begin
                  // first shock only flags, a second one in a row moves the reference
                  if (!shock_wait) begin
                     shock_wait  = 1'b1;
                     due.verdict = VERDICT_SUSPECT;
                  end else begin
                     shock_wait  = 1'b0;
                     ref_ph      = PH_W'(med);
                     due.verdict = VERDICT_CONFIRM;
                  end
               end else begin
                  shock_wait  = 1'b0;
                  ref_ph      = PH_W'(med);
                  ref_ok      = 1'b1;
                  due.verdict = VERDICT_ACCEPT;
               end
            end
         end
         verdicts_due.push_back(due);
      endfunction

      function void compare_field(string name, logic [PH_W-1:0] want, logic [PH_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_verdict(verdict_beat_type got);
         verdict_beat_type want;
         if (verdicts_due.size() == 0) begin
            $error("verdict beat with no session end waiting for it");
            errors++;
            return;
         end
         want = verdicts_due.pop_front();
         compare_field("verdict", PH_W'(want.verdict), PH_W'(got.verdict));
         compare_field("median_ph", want.median, got.median);
         compare_field("spread_ph", want.spread, got.spread);
         compare_field("prior_reference", want.prior, got.prior);
         compare_field("prior_reference_valid", PH_W'(want.prior_ok), PH_W'(got.prior_ok));
         compare_field("change_ph", want.change, got.change);
         compare_field("kept_count", PH_W'(want.kept), PH_W'(got.kept));
         compare_field("reference_cleared", PH_W'(want.cleared), PH_W'(got.cleared));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [PH_W-1:0]        req_sample_ph;
   logic                   req_read_ok;
   logic                   req_session_end;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [VERDICT_W-1:0]   rsp_verdict;
   logic [PH_W-1:0]        rsp_median_ph;
   logic [PH_W-1:0]        rsp_spread_ph;
   logic [PH_W-1:0]        rsp_prior_reference;
   logic                   rsp_prior_reference_valid;
   logic [PH_W-1:0]        rsp_change_ph;
   logic [KEEP_W-1:0]      rsp_kept_count;
   logic                   rsp_reference_cleared;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [PH_W-1:0]        csr_wdata;

   session_verdict_board_type board;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   beats_sent    = 0;
   int                   drift_center  = 7000;
   int                   cycle_count   = 0;

   ph_session_median_qualifier u_top (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_sample_ph             (req_sample_ph),
      .req_read_ok               (req_read_ok),
      .req_session_end           (req_session_end),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_verdict               (rsp_verdict),
      .rsp_median_ph             (rsp_median_ph),
      .rsp_spread_ph             (rsp_spread_ph),
      .rsp_prior_reference       (rsp_prior_reference),
      .rsp_prior_reference_valid (rsp_prior_reference_valid),
      .rsp_change_ph             (rsp_change_ph),
      .rsp_kept_count            (rsp_kept_count),
      .rsp_reference_cleared     (rsp_reference_cleared),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_index                 (csr_index),
      .csr_wdata                 (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // random stall on the verdict channel
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < rsp_stall_pct);
   end

   // verdict beat monitor
   always @(posedge clock) begin
      verdict_beat_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.verdict  = verdict_type'(rsp_verdict);
         got.median   = rsp_median_ph;
         got.spread   = rsp_spread_ph;
         got.prior    = rsp_prior_reference;
         got.prior_ok = rsp_prior_reference_valid;
         got.change   = rsp_change_ph;
         got.kept     = rsp_kept_count;
         got.cleared  = rsp_reference_cleared;
         board.check_verdict(got);
      end
   end

   // one sample beat; valid stays high into the next beat unless a gap is drawn
   task automatic send_beat(logic [PH_W-1:0] ph, bit ok, bit last);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_ph   <= ph;
      req_read_ok     <= ok;
      req_session_end <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_sample(ph, ok, last);
      beats_sent++;
   endtask

   task automatic write_csr(csr_index_type idx, logic [PH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.note_config(idx, value);
   endtask

   task automatic load_settings(logic [PH_W-1:0] noise, logic [PH_W-1:0] shock,
                                logic [PH_W-1:0] lo, logic [PH_W-1:0] hi,
                                logic [RUN_W-1:0] run);
      write_csr(CSR_NOISE_LIMIT, noise);
      write_csr(CSR_SHOCK_LIMIT, shock);
      write_csr(CSR_VALID_LOW, lo);
      write_csr(CSR_VALID_HIGH, hi);
      write_csr(CSR_NOISY_RUN_LIMIT, PH_W'(run));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every owed verdict, then let the sequencer finish any sample work
   task automatic drain_block();
      req_valid <= 1'b0;
      while (board.verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one random session around a drifting center, last beat carries session_end
   task automatic send_session();
      int unsigned     len;
      int unsigned     amp;
      int unsigned     pick;
      int              v;
      int              lo_b;
      int              hi_b;
      logic [PH_W-1:0] ph;
      bit              ok;
      lo_b = (board.range_lo <= board.range_hi) ? int'(board.range_lo) : 0;
      hi_b = (board.range_lo <= board.range_hi) ? int'(board.range_hi) : PH_TOP;
      // mostly a small drift, sometimes a jump past the shock limit
      pick = $urandom_range(99, 0);
      if (pick < 25) begin
         v = int'(board.shock_lim) + int'($urandom_range(400, 1));
         drift_center += $urandom_range(1, 0) ? v : -v;
      end else begin
         v = int'(board.shock_lim) / 4;
         drift_center += int'($urandom_range(2 * v, 0)) - v;
      end
      if (drift_center < lo_b) drift_center = lo_b;
      if (drift_center > hi_b) drift_center = hi_b;
      // jitter amplitude: clean, likely noisy, or flat
      pick = $urandom_range(99, 0);
      if (pick < 45) amp = board.noise_lim / 2;
      else if (pick < 75) amp = board.noise_lim + $urandom_range(200, 1);
      else amp = 0;
      // an occasional session with nothing usable in it
      if ($urandom_range(99, 0) < 6) begin
         send_beat(PH_W'(drift_center), 1'b0, 1'b1);
         return;
      end
      len = $urandom_range(11, 1);
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(99, 0);
         if (pick < 8) begin
            ph = PH_W'($urandom_range(PH_TOP, 0));
            ok = 1'($urandom_range(1, 0));
         end else begin
            v = drift_center + int'($urandom_range(2 * amp, 0)) - int'(amp);
            if (v < 0) v = 0;
            if (v > PH_TOP) v = PH_TOP;
            ph = PH_W'(v);
            ok = (pick >= 15);
         end
         send_beat(ph, ok, k == len - 1);
      end
   endtask

   task automatic apply_phase_settings(int p);
      logic [PH_W-1:0] lo;
      case (p)
         0: load_settings(NOISE_LIMIT_RST, SHOCK_LIMIT_RST, VALID_LOW_RST, VALID_HIGH_RST,
                          NOISY_RUN_LIMIT_RST);
         // zero limits, full range, every noisy session clears
         1: load_settings(14'd0, 14'd0, 14'd0, 14'(PH_TOP), 4'd0);
         // top limits and the longest noisy run
         2: load_settings(14'(PH_TOP), 14'(PH_TOP), 14'd0, 14'(PH_TOP), 4'd15);
         // inverted range, nothing is kept
         3: load_settings(14'd300, 14'd400, 14'd9000, 14'd4000, 4'd1);
         // range of one value
         4: load_settings(14'd25, 14'd60, 14'd7000, 14'd7000, 4'd2);
         default: begin
            lo = PH_W'($urandom_range(9000, 0));
            load_settings(PH_W'($urandom_range(800, 0)), PH_W'($urandom_range(2000, 0)), lo,
                          PH_W'(lo + $urandom_range(PH_TOP - lo, 0)),
                          RUN_W'($urandom_range(15, 0)));
         end
      endcase
   endtask

   initial begin
      int start;
      board = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_sample_ph   <= '0;
      req_read_ok     <= 1'b0;
      req_session_end <= 1'b0;
      rsp_stall       <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_NOISE_LIMIT;
      csr_wdata       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed sessions under reset settings
      // empty session, no reference yet
      send_beat(14'd5000, 1'b0, 1'b1);
      // first accepted session sets the reference
      send_beat(14'd7000, 1'b1, 1'b1);
      // small change, even count
      send_beat(14'd7100, 1'b1, 1'b0);
      send_beat(14'd7050, 1'b1, 1'b1);
      // shock suspected, then confirmed
      send_beat(14'd8000, 1'b1, 1'b1);
      send_beat(14'd8000, 1'b1, 1'b1);
      // field extremes out of range and a failed read, only the last is kept
      send_beat(14'd0, 1'b1, 1'b0);
      send_beat(14'(PH_TOP), 1'b1, 1'b0);
      send_beat(14'd8200, 1'b0, 1'b0);
      send_beat(14'd8100, 1'b1, 1'b1);
      // three noisy sessions in a row clear the reference
      for (int i = 0; i < 3; i++) begin
         send_beat(14'd6000, 1'b1, 1'b0);
         send_beat(14'd6500, 1'b1, 1'b1);
      end
      // no reference after the clear
      send_beat(14'd7000, 1'b1, 1'b1);
      // store full, the ninth sample is dropped
      for (int i = 0; i < 9; i++) send_beat(PH_W'(7000 + 13 * i), 1'b1, i == 8);
      drain_block();

      // random phases, each with its own settings and idle pattern
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_phase_settings(p);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 71; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 71; end
            default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
         endcase
         drift_center = (board.range_lo <= board.range_hi) ?
                        (int'(board.range_lo) + int'(board.range_hi)) / 2 : 7000;
         start = beats_sent;
         while (beats_sent - start < PHASE_ITEMS) send_session();
         drain_block();
      end

      if (board.errors == 0 && board.verdicts_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
design/phsmq_pkg.sv
design/phsmq_alu.sv
design/ph_session_median_qualifier.sv
sim/testbench.sv
